// ===== rtl/fifo_buffer_pool_allocator_top_macros.svh =====
// Assertion macros used by the checker file of the buffer pool allocator.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef FIFO_BUFFER_POOL_ALLOCATOR_TOP_MACROS_SVH
`define FIFO_BUFFER_POOL_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FBPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fbpa_pkg.sv =====
// Package for the buffer pool allocator: sizes, register indexes, request codes,
// the ring memory port struct and the buffer count clamp. No dependencies.
package fbpa_pkg;

    localparam int MAX_BUFFERS = 256;
    localparam int ADDR_WIDTH  = 32;
    localparam int RING_SLOTS  = MAX_BUFFERS + 1;
    localparam int SLOT_W      = $clog2(RING_SLOTS);
    localparam int SIZE_W      = 17;
    localparam int COUNT_W     = 9;
    localparam int SPAN_W      = SLOT_W + SIZE_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_COUNT = 2'd2;

    // Request codes
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Register reset values
    localparam logic [ADDR_WIDTH-1:0] POOL_BASE_RST    = '0;
    localparam logic [SIZE_W-1:0]     BUFFER_SIZE_RST  = 17'd64;
    localparam logic [COUNT_W-1:0]    BUFFER_COUNT_RST = 9'd256;

    typedef struct packed {
        logic                  wr_en;
        logic [SLOT_W-1:0]     wr_slot;
        logic [ADDR_WIDTH-1:0] wr_data;
        logic                  rd_en;
        logic [SLOT_W-1:0]     rd_slot;
    } t_ring_req;

    // Clamp the programmed count into 1..MAX_BUFFERS.
    function automatic logic [SLOT_W-1:0] f_eff_count(input logic [COUNT_W-1:0] count);
        logic [SLOT_W-1:0] eff;
        if (count == '0) begin
            eff = SLOT_W'(1);
        end else if (int'(count) > MAX_BUFFERS) begin
            eff = SLOT_W'(MAX_BUFFERS);
        end else begin
            eff = SLOT_W'(count);
        end
        return eff;
    endfunction

endpackage

// ===== rtl/fbpa_if.sv =====
// Channel interfaces of the buffer pool allocator: request, response, configuration.
// Depends on fbpa_pkg.
interface fbpa_req_if import fbpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [ADDR_WIDTH-1:0] release_address;

    modport source (output valid, output req_type, output release_address, input ready);
    modport sink   (input valid, input req_type, input release_address, output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ADDR_WIDTH-1:0] grant_address;
    logic                  pool_hit;

    modport source (output valid, output grant_address, output pool_hit, input ready);
    modport sink   (input valid, input grant_address, input pool_hit, output ready);
endinterface

interface fbpa_cfg_if import fbpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fifo_buffer_pool_allocator_top.sv =====
// Channel   | Dir | Payload                                   | Beat
// i_req     | in  | req_type, release_address                 | valid & ready
// o_rsp     | out | grant_address, pool_hit                   | valid & ready
// i_cfg     | in  | index (0 base, 1 size, 2 count), data     | valid & ready
//
// Release and empty allocate: response registered in the cycle after the beat; no wait state.
// Allocate hit: the ring memory read data is registered, then loaded into the response register from S_READ.
// Reset and every write to a mapped register pass through the r_settle state (span multiply, tail reload);
// slot-written flip-flops replace any clearing pass, so no further wait.
// A held response stalls input unless it is taken in the same cycle.
//
// Top level of the buffer pool allocator. Depends on fbpa_pkg, fbpa_if,
// fbpa_ring_mem and fbpa_ctrl.
module fifo_buffer_pool_allocator_top import fbpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fbpa_req_if.sink   i_req,
    fbpa_rsp_if.source o_rsp,
    fbpa_cfg_if.sink   i_cfg
);

    t_ring_req             ring_req;
    logic [ADDR_WIDTH-1:0] ring_rdata;

    fbpa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .i_cfg        (i_cfg),
        .o_ring_req   (ring_req),
        .i_ring_rdata (ring_rdata)
    );

    fbpa_ring_mem u_ring_mem (
        .i_clk     (i_clk),
        .i_req     (ring_req),
        .o_rd_data (ring_rdata)
    );

endmodule

// ===== rtl/fbpa_ring_mem.sv =====
// Free-address ring storage: one write port, one read port, registered read data.
// Depends on fbpa_pkg.
module fbpa_ring_mem import fbpa_pkg::*; (
    input  logic                  i_clk,
    input  t_ring_req             i_req,
    output logic [ADDR_WIDTH-1:0] o_rd_data
);

    logic [ADDR_WIDTH-1:0] r_mem [RING_SLOTS];
    logic [ADDR_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_slot] <= i_req.wr_data;
        end
        // hold the last read word when no read is issued
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_slot];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/fbpa_ctrl.sv =====
// Allocator control: config registers, head/tail pointers, slot-written bits,
// ownership check and the response register. Depends on fbpa_pkg and fbpa_if.
module fbpa_ctrl import fbpa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fbpa_req_if.sink              i_req,
    fbpa_rsp_if.source            o_rsp,
    fbpa_cfg_if.sink              i_cfg,
    output t_ring_req             o_ring_req,
    input  logic [ADDR_WIDTH-1:0] i_ring_rdata
);

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state                  r_state, n_state;
    logic                    r_settle, n_settle;
    logic [ADDR_WIDTH-1:0]   r_pool_base, n_pool_base;
    logic [SIZE_W-1:0]       r_buffer_size, n_buffer_size;
    logic [COUNT_W-1:0]      r_buffer_count, n_buffer_count;
    logic [SPAN_W-1:0]       r_span, n_span;
    logic [SLOT_W-1:0]       r_head, n_head;
    logic [SLOT_W-1:0]       r_tail, n_tail;
    logic [ADDR_WIDTH-1:0]   r_head_addr, n_head_addr;
    logic [RING_SLOTS-1:0]   r_written, n_written;
    logic                    r_alloc_written, n_alloc_written;
    logic [ADDR_WIDTH-1:0]   r_alloc_addr, n_alloc_addr;
    logic                    r_out_valid, n_out_valid;
    logic [ADDR_WIDTH-1:0]   r_grant, n_grant;
    logic                    r_hit, n_hit;

    logic [SLOT_W-1:0]       eff_count;
    logic [SLOT_W-1:0]       head_next;
    logic [SLOT_W-1:0]       tail_next;
    logic                    ring_empty;
    logic                    ring_full;
    logic [ADDR_WIDTH-1:0]   rel_offset;
    logic                    owned;
    logic                    out_free;
    logic                    req_acc;
    logic                    cfg_acc;
    logic                    refill;
    t_ring_req               ring_req;

    assign eff_count  = f_eff_count(r_buffer_count);
    assign head_next  = (r_head == eff_count) ? '0 : r_head + SLOT_W'(1);
    assign tail_next  = (r_tail == eff_count) ? '0 : r_tail + SLOT_W'(1);
    assign ring_empty = (r_head == r_tail);
    assign ring_full  = (tail_next == r_head);
    assign rel_offset = i_req.release_address - r_pool_base;
    assign owned      = (i_req.release_address >= r_pool_base) &&
                        (rel_offset < ADDR_WIDTH'(r_span));
    assign out_free   = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE) && !r_settle && out_free;
    assign req_acc     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    always_comb begin
        n_state         = r_state;
        n_settle        = r_settle;
        n_pool_base     = r_pool_base;
        n_buffer_size   = r_buffer_size;
        n_buffer_count  = r_buffer_count;
        n_span          = r_span;
        n_head          = r_head;
        n_tail          = r_tail;
        n_head_addr     = r_head_addr;
        n_written       = r_written;
        n_alloc_written = r_alloc_written;
        n_alloc_addr    = r_alloc_addr;
        n_out_valid     = r_out_valid;
        n_grant         = r_grant;
        n_hit           = r_hit;
        refill          = 1'b0;
        ring_req        = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        // in the cycle after reset or a mapped config write: rebuild the derived pool state
        if (r_settle) begin
            n_tail      = eff_count;
            n_head_addr = r_pool_base;
            n_span      = SPAN_W'(eff_count) * SPAN_W'(r_buffer_size);
            n_settle    = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.req_type == REQ_ALLOC) begin
                        if (!ring_empty) begin
                            ring_req.rd_en  = 1'b1;
                            ring_req.rd_slot = r_head;
                            n_alloc_written = r_written[r_head];
                            n_alloc_addr    = r_head_addr;
                            n_head          = head_next;
                            n_head_addr     = (r_head == eff_count) ? r_pool_base :
                                              r_head_addr + ADDR_WIDTH'(r_buffer_size);
                            n_state         = S_READ;
                        end else begin
                            n_out_valid = 1'b1;
                            n_grant     = '0;
                            n_hit       = 1'b0;
                        end
                    end else begin
                        if (owned && !ring_full) begin
                            ring_req.wr_en   = 1'b1;
                            ring_req.wr_slot = r_tail;
                            ring_req.wr_data = i_req.release_address;
                            n_written[r_tail] = 1'b1;
                            n_tail           = tail_next;
                        end
                        n_out_valid = 1'b1;
                        n_grant     = '0;
                        n_hit       = owned && !ring_full;
                    end
                end
            end
            S_READ: begin
                // wait for the response register if the last beat is still held
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_grant     = r_alloc_written ? i_ring_rdata : r_alloc_addr;
                    n_hit       = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_acc) begin
            unique case (i_cfg.index)
                CFG_POOL_BASE: begin
                    n_pool_base = ADDR_WIDTH'(i_cfg.data);
                    refill      = 1'b1;
                end
                CFG_BUFFER_SIZE: begin
                    n_buffer_size = i_cfg.data[SIZE_W-1:0];
                    refill        = 1'b1;
                end
                CFG_BUFFER_COUNT: begin
                    n_buffer_count = i_cfg.data[COUNT_W-1:0];
                    refill         = 1'b1;
                end
                default: begin
                    refill = 1'b0;
                end
            endcase
        end

        if (refill) begin
            n_written = '0;
            n_head    = '0;
            n_settle  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_settle       <= 1'b1;
            r_pool_base    <= POOL_BASE_RST;
            r_buffer_size  <= BUFFER_SIZE_RST;
            r_buffer_count <= BUFFER_COUNT_RST;
            r_head         <= '0;
            r_tail         <= '0;
            r_written      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_settle       <= n_settle;
            r_pool_base    <= n_pool_base;
            r_buffer_size  <= n_buffer_size;
            r_buffer_count <= n_buffer_count;
            r_head         <= n_head;
            r_tail         <= n_tail;
            r_written      <= n_written;
            r_out_valid    <= n_out_valid;
        end
        r_span          <= n_span;
        r_head_addr     <= n_head_addr;
        r_alloc_written <= n_alloc_written;
        r_alloc_addr    <= n_alloc_addr;
        r_grant         <= n_grant;
        r_hit           <= n_hit;
    end

    assign o_ring_req          = ring_req;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.grant_address = r_grant;
    assign o_rsp.pool_hit      = r_hit;

endmodule

// ===== rtl/fbpa_checker.sv =====
// Port-level checks for the buffer pool allocator, bound to the top level.
// Depends on fbpa_pkg and fifo_buffer_pool_allocator_top_macros.svh.
`include "fifo_buffer_pool_allocator_top_macros.svh"

module fbpa_checker import fbpa_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  i_req_ready,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input logic [ADDR_WIDTH-1:0] i_rsp_grant_address,
    input logic                  i_rsp_pool_hit,
    input logic                  i_cfg_valid,
    input logic                  i_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index
);

    logic r_pending;
    logic req_beat;
    logic rsp_beat;
    logic cfg_beat;
    logic cfg_refill;

    assign req_beat = i_req_valid && i_req_ready;
    assign rsp_beat = i_rsp_valid && i_rsp_ready;
    assign cfg_beat = i_cfg_valid && i_cfg_ready;
    // only a write to a mapped register refills the pool
    assign cfg_refill = cfg_beat && (i_cfg_index == CFG_POOL_BASE ||
                                     i_cfg_index == CFG_BUFFER_SIZE ||
                                     i_cfg_index == CFG_BUFFER_COUNT);

    // track one request whose response is not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (req_beat) begin
            r_pending <= 1'b1;
        end else if (rsp_beat) begin
            r_pending <= 1'b0;
        end
    end

    `FBPA_ASSERT_NOW(a_rsp_has_req, i_rsp_valid, r_pending, "response without request")
    `FBPA_ASSERT_NOW(a_one_in_flight, req_beat, !r_pending || rsp_beat, "second request in flight")
    `FBPA_ASSERT_NEXT(a_cfg_settle, cfg_refill, !i_req_ready, "request taken during settle")
    `FBPA_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_grant_address) && $stable(i_rsp_pool_hit), "stalled response changed")

endmodule

bind fifo_buffer_pool_allocator_top fbpa_checker u_fbpa_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_grant_address (o_rsp.grant_address),
    .i_rsp_pool_hit      (o_rsp.pool_hit),
    .i_cfg_valid         (i_cfg.valid),
    .i_cfg_ready         (i_cfg.ready),
    .i_cfg_index         (i_cfg.index)
);

// ===== tb/tb_fifo_buffer_pool_allocator_top.sv =====
// Self-checking testbench for the buffer pool allocator: a directed table, then random
// phases, each result checked against the table's expected values or an in-bench model of the free ring.
// Depends on fbpa_pkg, fbpa_if and fifo_buffer_pool_allocator_top.
`timescale 1ns / 1ps

module tb_fifo_buffer_pool_allocator_top import fbpa_pkg::*; ();

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 118;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] grant;
        logic                  hit;
    } t_grant;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic                  req_kind;
        logic [ADDR_WIDTH-1:0] addr;
        logic                  typed;
        t_grant                want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fbpa_req_if req_bus ();
    fbpa_rsp_if rsp_bus ();
    fbpa_cfg_if cfg_bus ();

    fifo_buffer_pool_allocator_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Free ring model
    logic [ADDR_WIDTH-1:0] model_base;
    logic [SIZE_W-1:0]     model_size;
    logic [COUNT_W-1:0]    model_count;
    logic [ADDR_WIDTH-1:0] ring_addr [RING_SLOTS];
    bit                    ring_set  [RING_SLOTS];
    int unsigned           head_pos;
    int unsigned           tail_pos;

    t_grant                pending_grants [$];
    logic [ADDR_WIDTH-1:0] granted_bufs [$];
    t_row                  script [$];
    int unsigned           error_count = 0;
    bit                    gaps_on     = 1'b0;
    bit                    stalls_on   = 1'b0;
    bit                    calm_tail   = 1'b0;

    function automatic int unsigned eff_buffers();
        if (model_count == '0) return 1;
        if (model_count > MAX_BUFFERS) return MAX_BUFFERS;
        return model_count;
    endfunction

    function automatic void pool_refill();
        foreach (ring_set[s]) ring_set[s] = 1'b0;
        head_pos = 0;
        tail_pos = eff_buffers();
        granted_bufs.delete();
    endfunction

    function automatic void pool_config(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_POOL_BASE:    model_base  = val;
            CFG_BUFFER_SIZE:  model_size  = val[SIZE_W-1:0];
            CFG_BUFFER_COUNT: model_count = val[COUNT_W-1:0];
            default:          return;
        endcase
        pool_refill();
    endfunction

    function automatic void pool_serve(input logic kind, input logic [ADDR_WIDTH-1:0] addr,
                                       output t_grant res);
        int unsigned slots;
        int unsigned nxt;
        logic [63:0] span;
        logic [63:0] home;
        slots     = eff_buffers() + 1;
        res.grant = '0;
        res.hit   = 1'b0;
        if (head_pos >= slots) head_pos = 0;
        if (tail_pos >= slots) tail_pos = 0;
        if (kind == REQ_ALLOC) begin
            if (head_pos != tail_pos) begin
                // an untouched slot still holds its buffer in address order
                home      = 64'(model_base) + 64'(head_pos) * 64'(model_size);
                res.grant = ring_set[head_pos] ? ring_addr[head_pos] : home[ADDR_WIDTH-1:0];
                res.hit   = 1'b1;
                head_pos  = (head_pos + 1) % slots;
            end
        end else begin
            span = 64'(eff_buffers()) * 64'(model_size);
            if (addr >= model_base && 64'(addr - model_base) < span) begin
                nxt = (tail_pos + 1) % slots;
                if (nxt != head_pos) begin
                    ring_addr[tail_pos] = addr;
                    ring_set[tail_pos]  = 1'b1;
                    tail_pos            = nxt;
                    res.hit             = 1'b1;
                end
            end
        end
    endfunction

    function automatic t_row req_row(input logic kind, input logic [ADDR_WIDTH-1:0] addr);
        t_row row;
        row          = '0;
        row.kind     = ROW_REQ;
        row.req_kind = kind;
        row.addr     = addr;
        return row;
    endfunction

    function automatic t_row chk_row(input logic kind, input logic [ADDR_WIDTH-1:0] addr,
                                     input logic [ADDR_WIDTH-1:0] grant, input logic hit);
        t_row row;
        row            = req_row(kind, addr);
        row.typed      = 1'b1;
        row.want.grant = grant;
        row.want.hit   = hit;
        return row;
    endfunction

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        t_row row;
        row      = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.val  = val;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_WIDTH-1:0] got,
                                   input logic [ADDR_WIDTH-1:0] want);
        $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
        error_count++;
    endtask

    // Leave valid high after the beat unless a random gap lowers it; otherwise the caller lowers it.
    task automatic issue_request(input logic kind, input logic [ADDR_WIDTH-1:0] addr,
                                 input logic typed, input t_grant want);
        t_grant outcome;
        req_bus.valid           <= 1'b1;
        req_bus.req_type        <= kind;
        req_bus.release_address <= addr;
        @(posedge i_clk);
        while (req_bus.ready !== 1'b1) @(posedge i_clk);
        pool_serve(kind, addr, outcome);
        if (kind == REQ_ALLOC && outcome.hit) granted_bufs.push_back(outcome.grant);
        pending_grants.push_back(typed ? want : outcome);
        if (gaps_on && !calm_tail && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (cfg_bus.ready !== 1'b1) @(posedge i_clk);
        pool_config(idx, val);
    endtask

    task automatic drain_responses();
        // lower valid only if a request left it high
        if (req_bus.valid !== 1'b0) req_bus.valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
    endtask

    // Sample the response beat at the rising edge, check it at the falling edge.
    logic                  rsp_beat = 1'b0;
    logic [ADDR_WIDTH-1:0] rsp_grant;
    logic                  rsp_hit;

    always @(posedge i_clk) begin
        rsp_beat  <= i_rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1;
        rsp_grant <= rsp_bus.grant_address;
        rsp_hit   <= rsp_bus.pool_hit;
    end

    always @(negedge i_clk) begin : grant_check
        t_grant want;
        if (rsp_beat) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("response with nothing pending", rsp_grant, '0);
            end else begin
                want = pending_grants.pop_front();
                if (rsp_grant !== want.grant) report_mismatch("grant_address", rsp_grant, want.grant);
                if (rsp_hit !== want.hit) report_mismatch("pool_hit", 32'(rsp_hit), 32'(want.hit));
            end
        end
    end

    initial begin : rsp_throttle
        int unsigned run_len;
        rsp_bus.ready <= 1'b1;
        forever begin
            run_len = $urandom_range(1, 20);
            repeat (run_len) @(posedge i_clk);
            if (stalls_on && !calm_tail && $urandom_range(0, 2) != 0) begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #400_000;
        $display("** fifo_buffer_pool_allocator_top: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] base_v;
        logic [CFG_DATA_W-1:0] size_v;
        logic [CFG_DATA_W-1:0] count_v;
        logic [ADDR_WIDTH-1:0] addr;
        logic                  kind;
        int unsigned           hold_at;
        int unsigned           alloc_bias;
        int unsigned           k;
        int unsigned           sel;

        i_rst_n                 <= 1'b0;
        req_bus.valid           <= 1'b0;
        req_bus.req_type        <= REQ_ALLOC;
        req_bus.release_address <= '0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.index           <= CFG_POOL_BASE;
        cfg_bus.data            <= '0;

        model_base  = POOL_BASE_RST;
        model_size  = BUFFER_SIZE_RST;
        model_count = BUFFER_COUNT_RST;
        pool_refill();

        // Reset pool: 256 buffers of 64 bytes at zero
        script.push_back(chk_row(REQ_ALLOC,   32'h0000_0000, 32'h0000_0000, 1'b1));
        script.push_back(chk_row(REQ_ALLOC,   32'hFFFF_FFFF, 32'h0000_0040, 1'b1));
        script.push_back(chk_row(REQ_RELEASE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
        script.push_back(chk_row(REQ_RELEASE, 32'h0000_0040, 32'h0000_0000, 1'b1));
        script.push_back(chk_row(REQ_RELEASE, 32'h0000_0000, 32'h0000_0000, 1'b1));
        // ring full: owned address is dropped
        script.push_back(chk_row(REQ_RELEASE, 32'h0000_0064, 32'h0000_0000, 1'b0));
        // Three 8-byte buffers wrapping past the top of the address space
        script.push_back(cfg_row(CFG_POOL_BASE,    32'hFFFF_FFF0));
        script.push_back(cfg_row(CFG_BUFFER_SIZE,  32'd8));
        script.push_back(cfg_row(CFG_BUFFER_COUNT, 32'd3));
        script.push_back(chk_row(REQ_ALLOC,   32'h0000_0000, 32'hFFFF_FFF0, 1'b1));
        script.push_back(chk_row(REQ_ALLOC,   32'h0000_0000, 32'hFFFF_FFF8, 1'b1));
        script.push_back(chk_row(REQ_ALLOC,   32'h0000_0000, 32'h0000_0000, 1'b1));
        script.push_back(chk_row(REQ_ALLOC,   32'h0000_0000, 32'h0000_0000, 1'b0));
        script.push_back(chk_row(REQ_RELEASE, 32'h0000_0000, 32'h0000_0000, 1'b0));
        script.push_back(chk_row(REQ_RELEASE, 32'hFFFF_FFF8, 32'h0000_0000, 1'b1));
        script.push_back(req_row(REQ_ALLOC,   32'h0000_0000));
        // Count of zero acts as one; oversize field truncates to 17 bits
        script.push_back(cfg_row(CFG_POOL_BASE,    32'h0000_0000));
        script.push_back(cfg_row(CFG_BUFFER_SIZE,  32'hFFFF_FFFF));
        script.push_back(cfg_row(CFG_BUFFER_COUNT, 32'd0));
        script.push_back(chk_row(REQ_ALLOC,   32'h0000_0000, 32'h0000_0000, 1'b1));
        script.push_back(chk_row(REQ_ALLOC,   32'h0000_0000, 32'h0000_0000, 1'b0));
        script.push_back(chk_row(REQ_RELEASE, 32'h0001_FFFE, 32'h0000_0000, 1'b1));
        script.push_back(chk_row(REQ_RELEASE, 32'h0001_FFFF, 32'h0000_0000, 1'b0));
        script.push_back(req_row(REQ_ALLOC,   32'h0000_0000));
        // Zero size owns nothing
        script.push_back(cfg_row(CFG_BUFFER_SIZE,  32'd0));
        script.push_back(chk_row(REQ_RELEASE, 32'h0000_0000, 32'h0000_0000, 1'b0));
        script.push_back(chk_row(REQ_ALLOC,   32'h0000_0000, 32'h0000_0000, 1'b1));
        // Count above the ring clamps; unmapped index leaves the ring alone
        script.push_back(cfg_row(CFG_POOL_BASE,    32'h1234_5678));
        script.push_back(cfg_row(CFG_BUFFER_SIZE,  32'h0001_0000));
        script.push_back(cfg_row(CFG_BUFFER_COUNT, 32'h0000_01FF));
        script.push_back(chk_row(REQ_ALLOC,   32'h0000_0000, 32'h1234_5678, 1'b1));
        script.push_back(cfg_row(CFG_UNMAPPED,     32'hFFFF_FFFF));
        script.push_back(chk_row(REQ_ALLOC,   32'h0000_0000, 32'h1235_5678, 1'b1));
        script.push_back(chk_row(REQ_RELEASE, 32'h1333_5678, 32'h0000_0000, 1'b1));
        script.push_back(chk_row(REQ_RELEASE, 32'h1334_5678, 32'h0000_0000, 1'b0));
        script.push_back(req_row(REQ_ALLOC,   32'h0000_0000));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        foreach (script[r]) begin
            if (script[r].kind == ROW_CFG) begin
                if (r == 0 || script[r-1].kind != ROW_CFG) drain_responses();
                write_reg(script[r].idx, script[r].val);
                if (r + 1 == script.size() || script[r+1].kind != ROW_CFG) cfg_bus.valid <= 1'b0;
            end else begin
                issue_request(script[r].req_kind, script[r].addr, script[r].typed, script[r].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    base_v  = 32'hFFFF_FFFF;
                    size_v  = 32'h0001_0000;
                    count_v = 32'd256;
                end
                1: begin
                    base_v  = 32'h0000_0000;
                    size_v  = 32'd8;
                    count_v = 32'd1;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       base_v = 32'h0000_0000;
                        1:       base_v = 32'hFFFF_F000;
                        default: base_v = $urandom();
                    endcase
                    case ($urandom_range(0, 5))
                        0:       size_v = $urandom_range(0, 255);
                        1:       size_v = $urandom();
                        2:       size_v = 32'h0001_FFFF;
                        default: size_v = $urandom_range(1, 64) * 8;
                    endcase
                    case ($urandom_range(0, 5))
                        0:       count_v = 32'd256;
                        1:       count_v = $urandom();
                        2:       count_v = 32'd0;
                        default: count_v = $urandom_range(1, 8);
                    endcase
                end
            endcase

            drain_responses();
            write_reg(CFG_POOL_BASE, base_v);
            write_reg(CFG_BUFFER_SIZE, size_v);
            write_reg(CFG_BUFFER_COUNT, count_v);
            if ($urandom_range(0, 3) == 0) write_reg(CFG_UNMAPPED, $urandom());
            cfg_bus.valid <= 1'b0;

            gaps_on    = $urandom_range(0, 3) != 0;
            stalls_on  = $urandom_range(0, 3) != 0;
            calm_tail  = phase == PHASES - 1;
            hold_at    = $urandom_range(10, PHASE_ITEMS - 10);
            alloc_bias = 50;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == hold_at) drain_responses();
                // swing between draining and refilling the ring
                if (n % 16 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       alloc_bias = 15;
                        1:       alloc_bias = 85;
                        default: alloc_bias = 50;
                    endcase
                end
                addr = $urandom();
                if ($urandom_range(0, 99) < alloc_bias) begin
                    kind = REQ_ALLOC;
                end else begin
                    kind = REQ_RELEASE;
                    sel  = $urandom_range(0, 9);
                    if (sel < 5 && granted_bufs.size() != 0) begin
                        k    = $urandom_range(0, granted_bufs.size() - 1);
                        addr = granted_bufs[k];
                        granted_bufs.delete(k);
                    end else if (sel < 8) begin
                        k    = $urandom_range(0, eff_buffers() - 1);
                        addr = model_base + k * model_size;
                        if (model_size != '0) addr = addr + $urandom_range(0, model_size - 1);
                    end else if (sel == 8) begin
                        case ($urandom_range(0, 2))
                            0:       addr = model_base - 1;
                            1:       addr = model_base + eff_buffers() * model_size;
                            default: addr = model_base + eff_buffers() * model_size - 1;
                        endcase
                    end
                end
                issue_request(kind, addr, 1'b0, '0);
            end
        end

        drain_responses();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** fifo_buffer_pool_allocator_top: PASSED **");
        end else begin
            $display("** fifo_buffer_pool_allocator_top: FAILED **");
        end
        $finish;
    end

endmodule
